/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the rectangle collision block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable.
`define RCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rcs assertion failed");

// Same-cycle implication.
`define RCS_IMPLY(lbl, clk, rst_n, ante, cons) \
  `RCS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

/* rtl/rcs_pkg.sv */
// ----------------------------------------------------------------------------
// rcs_pkg
// Types, codes and helpers shared by the rectangle collision block.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned RectSlotsDef = 5;
  localparam int unsigned SlotW        = 3;

  // flag bit positions
  localparam int unsigned FlBlocking  = 0;
  localparam int unsigned FlBlockable = 1;
  localparam int unsigned FlActive    = 2;
  localparam int unsigned FlOwner     = 3;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_STEP = 2'd1,
    MODE_READ = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_FETCH,
    DP_MOVE,
    DP_CHECK,
    DP_PUSH_A,
    DP_PUSH_B,
    DP_EMIT_EV_A,
    DP_EMIT_EV_B,
    DP_EMIT_DONE,
    DP_EMIT_READ
  } dp_op_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [SlotW-1:0]   slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [3:0]         flags;
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SlotW-1:0]   subject_slot;
    logic [SlotW-1:0]   other_slot;
    logic [1:0]         direction;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               last;
  } res_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0]        sw;
    logic [14:0]        sh;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic [3:0]         fl;
    logic               vld;
  } rect_t;

  // controller -> datapath
  typedef struct packed {
    dp_op_e           op;
    logic [SlotW-1:0] ia;
    logic [SlotW-1:0] ib;
    logic             ax;   // 1 vertical, 0 horizontal
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic ev_a;
    logic ev_b;
  } sts_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

/* rtl/rcs_if.sv */
// ----------------------------------------------------------------------------
// rcs_in_if / rcs_out_if
// Valid/ready channels carrying input items and result beats.
// ----------------------------------------------------------------------------
interface rcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        width;
  logic [14:0]        height;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic               is_blocking;
  logic               is_blockable;
  logic               is_active;
  logic               has_owner;

  modport source (output valid, mode, slot, pos_x, pos_y, width, height, vel_x, vel_y,
                  is_blocking, is_blockable, is_active, has_owner, input ready);
  modport sink (input valid, mode, slot, pos_x, pos_y, width, height, vel_x, vel_y,
                is_blocking, is_blockable, is_active, has_owner, output ready);
endinterface

interface rcs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         subject_slot;
  logic [2:0]         other_slot;
  logic [1:0]         direction;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               last;

  modport source (output valid, kind, subject_slot, other_slot, direction, out_x, out_y,
                  last, input ready);
  modport sink (input valid, kind, subject_slot, other_slot, direction, out_x, out_y,
                last, output ready);
endinterface

/* rtl/rcs_dp.sv */
// ----------------------------------------------------------------------------
// rcs_dp
// Rectangle table, pair working registers, move/overlap/push units, result reg.
// ----------------------------------------------------------------------------
module rcs_dp import rcs_pkg::*; #(
  parameter int unsigned RectSlots = RectSlotsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_acc_i,
  input  item_t item_i,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output res_t  res_o
);

  localparam int unsigned IdxW = $clog2(RectSlots);

  rect_t                 tab_q [RectSlots];
  logic [RectSlots-1:0]  vld_q;
  item_t                 item_q;
  rect_t                 a_q, b_q;
  logic                  hit_q, ab_q, ba_q;
  logic                  out_valid_q;
  res_t                  res_q;

  logic [IdxW-1:0] ia, ib;
  assign ia = cmd_i.ia[IdxW-1:0];
  assign ib = cmd_i.ib[IdxW-1:0];

  // table entries with their valid bit taken from the reset-cleared flags
  rect_t fetch_a, fetch_b;
  always_comb begin
    fetch_a     = tab_q[ia];
    fetch_a.vld = vld_q[ia];
    fetch_b     = tab_q[ib];
    fetch_b.vld = vld_q[ib];
  end

  // axis views
  logic signed [17:0] a_p, b_p, a_v, b_v, a_s, b_s;
  assign a_p = cmd_i.ax ? 18'(a_q.py) : 18'(a_q.px);
  assign b_p = cmd_i.ax ? 18'(b_q.py) : 18'(b_q.px);
  assign a_v = cmd_i.ax ? 18'(a_q.vy) : 18'(a_q.vx);
  assign b_v = cmd_i.ax ? 18'(b_q.vy) : 18'(b_q.vx);
  assign a_s = $signed({3'b000, cmd_i.ax ? a_q.sh : a_q.sw});
  assign b_s = $signed({3'b000, cmd_i.ax ? b_q.sh : b_q.sw});

  logic gt_a, gt_b;
  assign gt_a = a_v > b_v;
  assign gt_b = b_v > a_v;

  logic signed [15:0] move_p, push_a_p, push_b_p;
  assign move_p   = sat16(a_p + a_v);
  assign push_a_p = sat16(gt_a ? (b_p - a_s) : (b_p + b_s));
  assign push_b_p = sat16(gt_b ? (a_p - b_s) : (a_p + a_s));

  // strict overlap on both axes
  logic ovl;
  assign ovl = (18'(a_q.px) < 18'(b_q.px) + $signed({3'b000, b_q.sw})) &&
               (18'(a_q.py) < 18'(b_q.py) + $signed({3'b000, b_q.sh})) &&
               (18'(b_q.px) < 18'(a_q.px) + $signed({3'b000, a_q.sw})) &&
               (18'(b_q.py) < 18'(a_q.py) + $signed({3'b000, a_q.sh}));

  logic ab, ba, any_act;
  assign ab      = a_q.fl[FlBlockable] & b_q.fl[FlBlocking];
  assign ba      = b_q.fl[FlBlockable] & a_q.fl[FlBlocking];
  assign any_act = a_q.fl[FlActive] | b_q.fl[FlActive];

  logic [1:0] dir_a, dir_b;
  assign dir_a = cmd_i.ax ? (gt_a ? DIR_UP : DIR_DOWN) : (gt_a ? DIR_RIGHT : DIR_LEFT);
  assign dir_b = cmd_i.ax ? (gt_b ? DIR_UP : DIR_DOWN) : (gt_b ? DIR_RIGHT : DIR_LEFT);

  logic load_ok, rd_ok;
  assign load_ok = (item_q.mode == MODE_LOAD) && (item_q.slot < SlotW'(RectSlots));
  assign rd_ok   = (item_q.slot < SlotW'(RectSlots)) && a_q.vld;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.out_free = out_free;
  assign sts_o.ev_a     = hit_q & a_q.fl[FlActive] & a_q.fl[FlOwner];
  assign sts_o.ev_b     = hit_q & b_q.fl[FlActive] & b_q.fl[FlOwner];

  // valid bits and result-valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_LOAD && load_ok) begin
        vld_q[item_q.slot[IdxW-1:0]] <= 1'b1;
      end
      if (cmd_i.op == DP_EMIT_EV_A || cmd_i.op == DP_EMIT_EV_B ||
          cmd_i.op == DP_EMIT_DONE || cmd_i.op == DP_EMIT_READ) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table, working registers and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      item_q <= item_i;
    end
    unique case (cmd_i.op)
      DP_LOAD: begin
        if (load_ok) begin
          tab_q[item_q.slot[IdxW-1:0]] <= '{px: item_q.pos_x, py: item_q.pos_y,
                                           sw: item_q.width, sh: item_q.height,
                                           vx: item_q.vel_x, vy: item_q.vel_y,
                                           fl: item_q.flags, vld: 1'b1};
        end
      end
      DP_FETCH: begin
        a_q <= fetch_a;
        b_q <= fetch_b;
      end
      DP_MOVE: begin
        if (a_q.vld) begin
          if (cmd_i.ax) begin
            tab_q[ia].py <= move_p;
          end else begin
            tab_q[ia].px <= move_p;
          end
        end
      end
      DP_CHECK: begin
        hit_q <= a_q.vld & b_q.vld & (ab | ba | any_act) & ovl;
        ab_q  <= ab;
        ba_q  <= ba;
      end
      DP_PUSH_A: begin
        if (hit_q && ab_q) begin
          if (cmd_i.ax) begin
            tab_q[ia].py <= push_a_p;
            a_q.py       <= push_a_p;
          end else begin
            tab_q[ia].px <= push_a_p;
            a_q.px       <= push_a_p;
          end
        end
      end
      DP_PUSH_B: begin
        if (hit_q && ba_q) begin
          if (cmd_i.ax) begin
            tab_q[ib].py <= push_b_p;
          end else begin
            tab_q[ib].px <= push_b_p;
          end
        end
      end
      DP_EMIT_EV_A: begin
        res_q <= '{kind: KIND_EVENT, subject_slot: cmd_i.ia, other_slot: cmd_i.ib,
                   direction: dir_a, out_x: '0, out_y: '0, last: 1'b0};
      end
      DP_EMIT_EV_B: begin
        res_q <= '{kind: KIND_EVENT, subject_slot: cmd_i.ib, other_slot: cmd_i.ia,
                   direction: dir_b, out_x: '0, out_y: '0, last: 1'b0};
      end
      DP_EMIT_DONE: begin
        res_q <= '{kind: KIND_DONE, subject_slot: '0, other_slot: '0,
                   direction: DIR_UP, out_x: '0, out_y: '0, last: 1'b1};
      end
      DP_EMIT_READ: begin
        res_q <= '{kind: KIND_READ, subject_slot: item_q.slot, other_slot: '0,
                   direction: DIR_UP, out_x: rd_ok ? a_q.px : 16'sd0,
                   out_y: rd_ok ? a_q.py : 16'sd0, last: 1'b1};
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/rcs_ctrl.sv */
// ----------------------------------------------------------------------------
// rcs_ctrl
// Sequencer: load, read, and the two-axis move and pair walk of a frame.
// ----------------------------------------------------------------------------
module rcs_ctrl import rcs_pkg::*; #(
  parameter int unsigned RectSlots = RectSlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_mode_i,
  input  logic [SlotW-1:0] in_slot_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  localparam int unsigned IdxW = $clog2(RectSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RectSlots - 1);
  localparam logic [IdxW-1:0] PenIdx  = IdxW'(RectSlots - 2);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RFETCH, S_REMIT, S_MFETCH, S_MOVE, S_PFETCH,
    S_CHECK, S_PUSHA, S_PUSHB, S_EVA, S_EVB, S_DONE
  } state_e;

  state_e           state_q;
  logic [IdxW-1:0]  i_q, j_q;
  logic             ax_q;
  logic [SlotW-1:0] slot_q;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  logic [SlotW-1:0] rd_idx;
  assign rd_idx = (slot_q < SlotW'(RectSlots)) ? slot_q : '0;

  always_comb begin
    cmd_o.ia = SlotW'(i_q);
    cmd_o.ib = SlotW'(j_q);
    cmd_o.ax = ax_q;
    unique case (state_q)
      S_LOAD:   cmd_o.op = DP_LOAD;
      S_RFETCH: begin
        cmd_o.op = DP_FETCH;
        cmd_o.ia = rd_idx;
      end
      S_REMIT:  cmd_o.op = sts_i.out_free ? DP_EMIT_READ : DP_NOP;
      S_MFETCH, S_PFETCH: cmd_o.op = DP_FETCH;
      S_MOVE:   cmd_o.op = DP_MOVE;
      S_CHECK:  cmd_o.op = DP_CHECK;
      S_PUSHA:  cmd_o.op = DP_PUSH_A;
      S_PUSHB:  cmd_o.op = DP_PUSH_B;
      S_EVA:    cmd_o.op = (sts_i.ev_a && sts_i.out_free) ? DP_EMIT_EV_A : DP_NOP;
      S_EVB:    cmd_o.op = (sts_i.ev_b && sts_i.out_free) ? DP_EMIT_EV_B : DP_NOP;
      S_DONE:   cmd_o.op = sts_i.out_free ? DP_EMIT_DONE : DP_NOP;
      default:  cmd_o.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      ax_q    <= 1'b1;
      slot_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            slot_q <= in_slot_i;
            i_q    <= '0;
            ax_q   <= 1'b1;
            case (in_mode_i)
              MODE_STEP: state_q <= S_MFETCH;
              MODE_READ: state_q <= S_RFETCH;
              default:   state_q <= S_LOAD;  // load, or ignored mode
            endcase
          end
        end
        S_LOAD:   state_q <= S_IDLE;
        S_RFETCH: state_q <= S_REMIT;
        S_REMIT:  if (sts_i.out_free) state_q <= S_IDLE;
        S_MFETCH: state_q <= S_MOVE;
        S_MOVE: begin
          if (i_q == LastIdx) begin
            i_q     <= '0;
            j_q     <= IdxW'(1);
            state_q <= S_PFETCH;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_MFETCH;
          end
        end
        S_PFETCH: state_q <= S_CHECK;
        S_CHECK:  state_q <= S_PUSHA;
        S_PUSHA:  state_q <= S_PUSHB;
        S_PUSHB:  state_q <= S_EVA;
        S_EVA:    if (!sts_i.ev_a || sts_i.out_free) state_q <= S_EVB;
        S_EVB: begin
          if (!sts_i.ev_b || sts_i.out_free) begin
            // advance to next pair, next axis, or finish
            if (j_q != LastIdx) begin
              j_q     <= j_q + 1'b1;
              state_q <= S_PFETCH;
            end else if (i_q != PenIdx) begin
              i_q     <= i_q + 1'b1;
              j_q     <= i_q + IdxW'(2);
              state_q <= S_PFETCH;
            end else if (ax_q) begin
              ax_q    <= 1'b0;
              i_q     <= '0;
              state_q <= S_MFETCH;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_DONE:   if (sts_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/rect_collision_step_core.sv */
// ----------------------------------------------------------------------------
// rect_collision_step_core
// Rectangle table with per-frame move, overlap test, push-out and events.
// ----------------------------------------------------------------------------
// Load, read and step take one item at a time; no new item is taken until
// the current one finishes. Step: per axis, vertical first, a move pass over
//   all slots, then fetch, check, push A, push B and both event states for
//   each slot pair, then the done beat. Output stalls hold the sequencer.
// Reset clears slot valid bits and control; table contents stay undefined.
// ----------------------------------------------------------------------------
module rect_collision_step_core import rcs_pkg::*; #(
  parameter int unsigned RECT_SLOTS = RectSlotsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rcs_in_if.sink    in_i,
  rcs_out_if.source out_o
);

  cmd_t  cmd;
  sts_t  sts;
  item_t item;
  res_t  res;
  logic  in_acc;

  // pack the input beat; flags follow the package bit order
  assign item = '{mode: in_i.mode, slot: in_i.slot, pos_x: in_i.pos_x, pos_y: in_i.pos_y,
                  width: in_i.width, height: in_i.height, vel_x: in_i.vel_x,
                  vel_y: in_i.vel_y,
                  flags: {in_i.has_owner, in_i.is_active, in_i.is_blockable,
                          in_i.is_blocking}};
  assign in_acc = in_i.valid && in_i.ready;

  // controller: owns the pair walk and the output handshake timing
  rcs_ctrl #(.RectSlots(RECT_SLOTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_slot_i  (in_i.slot),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: table, arithmetic and the result register
  rcs_dp #(.RectSlots(RECT_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (res)
  );

  // unpack the result beat
  assign out_o.kind         = res.kind;
  assign out_o.subject_slot = res.subject_slot;
  assign out_o.other_slot   = res.other_slot;
  assign out_o.direction    = res.direction;
  assign out_o.out_x        = res.out_x;
  assign out_o.out_y        = res.out_y;
  assign out_o.last         = res.last;

endmodule

/* rtl/rcs_checker.sv */
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks of the collision block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcs_checker import rcs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] kind_i,
  input logic       last_i
);

  `RCS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i))
  `RCS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)
  `RCS_IMPLY(a_done_last, clk_i, rst_ni, out_valid_i && kind_i == KIND_DONE, last_i)
  `RCS_IMPLY(a_event_not_last, clk_i, rst_ni, out_valid_i && kind_i == KIND_EVENT, !last_i)
  `RCS_IMPLY(a_kind_legal, clk_i, rst_ni, out_valid_i, kind_i == KIND_EVENT || kind_i == KIND_DONE || kind_i == KIND_READ)

endmodule

bind rect_collision_step_core rcs_checker u_rcs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .kind_i      (out_o.kind),
  .last_i      (out_o.last)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Rectangle collision core testbench
// Loads rectangles, runs frames and reads positions back.
// A built-in frame predictor checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;
  import rcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSlots = RectSlotsDef;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rcs_in_if  item_ch ();
  rcs_out_if beat_ch ();

  rect_collision_step_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (beat_ch)
  );

  always #5 clk_i = ~clk_i;

  // Frame predictor state: index [axis][slot], axis 1 vertical, 0 horizontal.
  int       rect_pos [2][NSlots];
  int       rect_size[2][NSlots];
  int       rect_vel [2][NSlots];
  bit [3:0] rect_flags[NSlots];
  bit [NSlots-1:0] slot_used;

  res_t pending_beats[$];
  int   mismatch_cnt;
  int   burst_left;
  int   items_sent;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void expect_beat(kind_e kind, int subj, int oth, dir_e dir,
                                      int x, int y, bit last);
    res_t r;
    r.kind = kind;
    r.subject_slot = subj[2:0];
    r.other_slot = oth[2:0];
    r.direction = dir;
    r.out_x = x[15:0];
    r.out_y = y[15:0];
    r.last = last;
    pending_beats.insert(pending_beats.size(), r);
  endfunction

  function automatic bit rects_overlap(int a, int b);
    return rect_pos[0][a] < rect_pos[0][b] + rect_size[0][b] &&
           rect_pos[1][a] < rect_pos[1][b] + rect_size[1][b] &&
           rect_pos[0][b] < rect_pos[0][a] + rect_size[0][a] &&
           rect_pos[1][b] < rect_pos[1][a] + rect_size[1][a];
  endfunction

  // Push m out of blocker k: to k - size(m) if m is faster, else k + size(k).
  function automatic void push_out(int m, int k, int ax);
    if (rect_vel[ax][m] > rect_vel[ax][k])
      rect_pos[ax][m] = clamp16(rect_pos[ax][k] - rect_size[ax][m]);
    else
      rect_pos[ax][m] = clamp16(rect_pos[ax][k] + rect_size[ax][k]);
  endfunction

  function automatic dir_e event_dir(int s, int o, int ax);
    bit gt;
    gt = rect_vel[ax][s] > rect_vel[ax][o];
    if (ax == 1) return gt ? DIR_UP : DIR_DOWN;
    return gt ? DIR_RIGHT : DIR_LEFT;
  endfunction

  function automatic void resolve_axis(int ax);
    bit a_blk, b_blk, a_ev, b_ev;
    for (int i = 0; i < NSlots; i++)
      if (slot_used[i]) rect_pos[ax][i] = clamp16(rect_pos[ax][i] + rect_vel[ax][i]);
    for (int i = 0; i < NSlots; i++) begin
      if (!slot_used[i]) continue;
      for (int j = i + 1; j < NSlots; j++) begin
        if (!slot_used[j]) continue;
        a_blk = rect_flags[i][FlBlockable] && rect_flags[j][FlBlocking];
        b_blk = rect_flags[j][FlBlockable] && rect_flags[i][FlBlocking];
        if (!a_blk && !b_blk && !rect_flags[i][FlActive] && !rect_flags[j][FlActive])
          continue;
        if (!rects_overlap(i, j)) continue;
        if (a_blk) push_out(i, j, ax);
        if (b_blk) push_out(j, i, ax);
        a_ev = rect_flags[i][FlActive] && rect_flags[i][FlOwner];
        b_ev = rect_flags[j][FlActive] && rect_flags[j][FlOwner];
        if (a_ev) expect_beat(KIND_EVENT, i, j, event_dir(i, j, ax), 0, 0, 1'b0);
        if (b_ev) expect_beat(KIND_EVENT, j, i, event_dir(j, i, ax), 0, 0, 1'b0);
      end
    end
  endfunction

  // Update the table and queue the beats caused by one accepted item.
  function automatic void predict_item(bit [1:0] mode, bit [2:0] slot, int px, int py,
                                       int w, int h, int vx, int vy, bit [3:0] fl);
    int x, y;
    case (mode)
      MODE_LOAD: begin
        if (slot < NSlots) begin
          rect_pos[0][slot] = px;  rect_pos[1][slot] = py;
          rect_size[0][slot] = w;  rect_size[1][slot] = h;
          rect_vel[0][slot] = vx;  rect_vel[1][slot] = vy;
          rect_flags[slot] = fl;
          slot_used[slot] = 1'b1;
        end
      end
      MODE_STEP: begin
        resolve_axis(1);
        resolve_axis(0);
        expect_beat(KIND_DONE, 0, 0, DIR_UP, 0, 0, 1'b1);
      end
      MODE_READ: begin
        x = 0;
        y = 0;
        if (slot < NSlots && slot_used[slot]) begin
          x = rect_pos[0][slot];
          y = rect_pos[1][slot];
        end
        expect_beat(KIND_READ, slot, 0, DIR_UP, x, y, 1'b1);
      end
      default: ;
    endcase
  endfunction

  // Send one item in bursts with random gaps; predict once the beat is taken.
  task automatic send_item(bit [1:0] mode, bit [2:0] slot, int px, int py,
                           int w, int h, int vx, int vy, bit [3:0] fl);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        item_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= mode;
    item_ch.slot         <= slot;
    item_ch.pos_x        <= px[15:0];
    item_ch.pos_y        <= py[15:0];
    item_ch.width        <= w[14:0];
    item_ch.height       <= h[14:0];
    item_ch.vel_x        <= vx[15:0];
    item_ch.vel_y        <= vy[15:0];
    item_ch.is_blocking  <= fl[FlBlocking];
    item_ch.is_blockable <= fl[FlBlockable];
    item_ch.is_active    <= fl[FlActive];
    item_ch.has_owner    <= fl[FlOwner];
    do @(posedge clk_i); while (!(item_ch.valid && item_ch.ready));
    predict_item(mode, slot, $signed(px[15:0]), $signed(py[15:0]), w[14:0], h[14:0],
                 $signed(vx[15:0]), $signed(vy[15:0]), fl);
    items_sent++;
  endtask

  task automatic load_rect(int s, int px, int py, int w, int h, int vx, int vy,
                           bit [3:0] fl);
    send_item(MODE_LOAD, 3'(s), px, py, w, h, vx, vy, fl);
  endtask

  task automatic read_rect(int s);
    send_item(MODE_READ, 3'(s), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 4'($urandom));
  endtask

  task automatic run_frame();
    send_item(MODE_STEP, 3'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, 4'($urandom));
  endtask

  // Hold the sender until every expected beat has come out.
  task automatic drain_beats();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  function automatic bit [3:0] flag_set(bit blk, bit able, bit act, bit own);
    bit [3:0] f;
    f = '0;
    f[FlBlocking] = blk;
    f[FlBlockable] = able;
    f[FlActive] = act;
    f[FlOwner] = own;
    return f;
  endfunction

  task automatic test_empty_table();
    run_frame();
    read_rect(0);
    read_rect(7);
    send_item(2'd3, 3'd1, 5, 5, 5, 5, 5, 5, 4'hF);
    load_rect(6, 100, 100, 16, 16, 0, 0, 4'hF);
    read_rect(6);
  endtask

  task automatic test_field_extremes();
    load_rect(0, -32768, 32767, 32767, 0, 32767, -32768, 4'h0);
    load_rect(4, 32767, -32768, 0, 32767, -32768, 32767, 4'hF);
    read_rect(0);
    read_rect(4);
    run_frame();
    read_rect(0);
    read_rect(4);
  endtask

  // Mover falls onto a floor, pushed up by its own height, events both ways; then rises into it.
  task automatic test_vertical_block();
    load_rect(0, 0, 160, 320, 32, 0, 0, flag_set(1, 0, 1, 1));
    load_rect(1, 16, 100, 48, 48, 0, 40, flag_set(0, 1, 1, 1));
    load_rect(4, 300, 0, 16, 16, 0, 0, 4'h0);
    run_frame();
    read_rect(1);
    load_rect(1, 16, 190, 48, 48, 0, -40, flag_set(0, 1, 1, 0));
    run_frame();
    read_rect(1);
  endtask

  task automatic test_horizontal_block();
    load_rect(2, 0, 0, 32, 64, 24, 0, flag_set(0, 1, 1, 1));
    load_rect(3, 40, 0, 32, 64, -8, 0, flag_set(1, 1, 1, 1));
    run_frame();
    read_rect(2);
    read_rect(3);
  endtask

  task automatic random_load(int s);
    load_rect(s, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
              $urandom_range(1, 160), $urandom_range(1, 160),
              $urandom_range(0, 80) - 40, $urandom_range(0, 80) - 40,
              ($urandom_range(0, 3) == 0) ? 4'($urandom) :
              flag_set(1'($urandom), 1'($urandom), 1'b1, 1'b1));
  endtask

  // Dense scenes of nearby rectangles, then frames and reads.
  task automatic test_random_scenes();
    int n;
    while (items_sent < 95) begin
      n = $urandom_range(2, NSlots);
      for (int s = 0; s < n; s++) random_load($urandom_range(0, NSlots - 1));
      repeat ($urandom_range(1, 4)) begin
        run_frame();
        if ($urandom_range(0, 1)) read_rect($urandom_range(0, 7));
      end
      if ($urandom_range(0, 5) == 0) drain_beats();
    end
  endtask

  // Full-range fields, including saturating moves.
  task automatic test_random_noise();
    repeat (25) begin
      send_item(2'($urandom), 3'($urandom), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, 4'($urandom));
    end
  endtask

  // Receiver: drives ready in one of four stall styles, picked at random.
  int stall_style;
  int stall_cnt;
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: beat_ch.ready <= 1'b1;
      1: beat_ch.ready <= ($urandom_range(0, 9) < 7);
      2: beat_ch.ready <= (stall_cnt % 4 == 0);
      default: beat_ch.ready <= ((stall_cnt % 32) > 20);
    endcase
  end

  // Compare each beat with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && beat_ch.valid && beat_ch.ready) begin
      if (pending_beats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat kind=%0d subj=%0d", beat_ch.kind, beat_ch.subject_slot);
      end else begin
        want = pending_beats.pop_front();
        if (beat_ch.kind !== want.kind || beat_ch.subject_slot !== want.subject_slot ||
            beat_ch.other_slot !== want.other_slot || beat_ch.direction !== want.direction ||
            beat_ch.out_x !== want.out_x || beat_ch.out_y !== want.out_y ||
            beat_ch.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("beat mismatch: exp k=%0d s=%0d o=%0d d=%0d x=%0d y=%0d l=%0d %s",
                     want.kind, want.subject_slot, want.other_slot, want.direction,
                     want.out_x, want.out_y, want.last,
                     $sformatf("got k=%0d s=%0d o=%0d d=%0d x=%0d y=%0d l=%0d",
                               beat_ch.kind, beat_ch.subject_slot, beat_ch.other_slot,
                               beat_ch.direction, beat_ch.out_x, beat_ch.out_y,
                               beat_ch.last));
        end
      end
    end
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.mode = MODE_LOAD;
    item_ch.slot = '0;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.width = '0;
    item_ch.height = '0;
    item_ch.vel_x = '0;
    item_ch.vel_y = '0;
    item_ch.is_blocking = 1'b0;
    item_ch.is_blockable = 1'b0;
    item_ch.is_active = 1'b0;
    item_ch.has_owner = 1'b0;
    beat_ch.ready = 1'b0;
    stall_cnt = 0;
    stall_style = 0;
    slot_used = '0;
    mismatch_cnt = 0;
    burst_left = 0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_field_extremes();
    drain_beats();
    test_vertical_block();
    test_horizontal_block();
    test_random_scenes();
    test_random_noise();

    drain_beats();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rcs_pkg.sv
rtl/rcs_if.sv
rtl/rcs_dp.sv
rtl/rcs_ctrl.sv
rtl/rect_collision_step_core.sv
rtl/rcs_checker.sv
test/tb.sv
